FILE: rtl/core/pcdp_pkg.sv
// ----------------------------------------------------------------------------
// PWM change packer package
// Shared widths, length constants, command codes and the packer result type.
// ----------------------------------------------------------------------------
`default_nettype none

package pcdp_pkg;

  localparam int unsigned ALL_CHANNELS      = 16;
  localparam int unsigned BYTE_W            = 8;
  localparam int unsigned PWM_W             = ALL_CHANNELS * BYTE_W;
  localparam int unsigned HALF_W            = PWM_W / 2;
  localparam int unsigned ADDR_IN_W         = 6;
  localparam int unsigned ADDR_IN_N         = 1 << ADDR_IN_W;
  localparam int unsigned DIRECT_W          = 16;
  localparam int unsigned CNT_W             = 5;
  localparam int unsigned LEN_W             = 5;

  localparam logic [LEN_W-1:0] LEN_DATA_ONLY    = LEN_W'(2);
  localparam logic [LEN_W-1:0] LEN_PWM_OVERHEAD = LEN_W'(4);

  localparam int unsigned DEF_NUM_ADDRESSES = 64;
  localparam int unsigned DEF_PWM_CHANNELS  = 16;

  typedef enum logic [0:0] {
    CMD_DATA_ONLY = 1'b0,
    CMD_PWM       = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [CNT_W-1:0]  count;
    logic [LEN_W-1:0]  length;
    logic [PWM_W-1:0]  packed_bytes;
  } pack_res_t;

endpackage

`default_nettype wire

FILE: rtl/core/pcdp_in_if.sv
// ----------------------------------------------------------------------------
// PWM change packer input channel
// One output image word: module address, stop flag, direct bits, PWM bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcdp_in_if;
  logic        valid;
  logic        ready;
  logic [5:0]  module_address;
  logic        stop_io;
  logic [15:0] direct_outputs;
  logic [63:0] pwm_bytes_low;
  logic [63:0] pwm_bytes_high;

  modport source (
    output valid, module_address, stop_io, direct_outputs, pwm_bytes_low,
           pwm_bytes_high,
    input  ready
  );

  modport sink (
    input  valid, module_address, stop_io, direct_outputs, pwm_bytes_low,
           pwm_bytes_high,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/pcdp_out_if.sv
// ----------------------------------------------------------------------------
// PWM change packer output channel
// One command word: kind, sent outputs, change mask, packed bytes, length.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcdp_out_if;
  logic        valid;
  logic        ready;
  logic        command_kind;
  logic [15:0] sent_outputs;
  logic [15:0] changed_mask;
  logic [4:0]  changed_count;
  logic [63:0] packed_low;
  logic [63:0] packed_high;
  logic [4:0]  send_length;

  modport source (
    output valid, command_kind, sent_outputs, changed_mask, changed_count,
           packed_low, packed_high, send_length,
    input  ready
  );

  modport sink (
    input  valid, command_kind, sent_outputs, changed_mask, changed_count,
           packed_low, packed_high, send_length,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/pcdp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pcdp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/pcdp_lane.sv
// ----------------------------------------------------------------------------
// PWM change packer lane
// Compares one PWM channel byte with the byte last sent on that channel.
// ----------------------------------------------------------------------------
`default_nettype none

module pcdp_lane #(
  parameter bit ACTIVE = 1'b1
) (
  input  wire logic [pcdp_pkg::BYTE_W-1:0] byte_i,
  input  wire logic [pcdp_pkg::BYTE_W-1:0] prev_i,
  output logic      [pcdp_pkg::BYTE_W-1:0] fresh_o,
  output logic                             changed_o
);
  import pcdp_pkg::*;

  // Channels above the configured count are held at zero and never reported.
  assign fresh_o   = ACTIVE ? byte_i : '0;
  assign changed_o = ACTIVE && (byte_i != prev_i);

endmodule

`default_nettype wire

FILE: rtl/core/pcdp_merge.sv
// ----------------------------------------------------------------------------
// PWM change packer merge
// Packs the changed bytes in channel order and forms kind, count and length.
// ----------------------------------------------------------------------------
`default_nettype none

module pcdp_merge (
  input  wire logic [pcdp_pkg::ALL_CHANNELS-1:0] mask_i,
  input  wire logic [pcdp_pkg::PWM_W-1:0]        fresh_i,
  output pcdp_pkg::pack_res_t                    res_o
);
  import pcdp_pkg::*;

  logic [CNT_W-1:0]  pos   [ALL_CHANNELS];
  logic [PWM_W-1:0]  packed_bytes;
  logic [CNT_W-1:0]  count;

  always_comb begin
    for (int c = 0; c < ALL_CHANNELS; c++) begin
      pos[c] = CNT_W'($countones(mask_i &
                                 ((ALL_CHANNELS'(1) << c) - ALL_CHANNELS'(1))));
    end
  end

  always_comb begin
    packed_bytes = '0;
    for (int k = 0; k < ALL_CHANNELS; k++) begin
      for (int c = 0; c < ALL_CHANNELS; c++) begin
        if (mask_i[c] && (pos[c] == CNT_W'(k))) begin
          packed_bytes[k*BYTE_W +: BYTE_W] = packed_bytes[k*BYTE_W +: BYTE_W] |
                                             fresh_i[c*BYTE_W +: BYTE_W];
        end
      end
    end
  end

  assign count = CNT_W'($countones(mask_i));

  always_comb begin
    res_o.count        = count;
    res_o.packed_bytes = packed_bytes;
    if (count != '0) begin
      res_o.kind   = CMD_PWM;
      res_o.length = LEN_W'(count + LEN_PWM_OVERHEAD);
    end else begin
      res_o.kind   = CMD_DATA_ONLY;
      res_o.length = LEN_DATA_ONLY;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/pwm_change_delta_packer.sv
// ----------------------------------------------------------------------------
// PWM change delta packer
// Turns cyclic output images into direct-only or changed-PWM commands.
// ----------------------------------------------------------------------------
// The input channel carries one output image per word: module address, stop
// flag, sixteen direct output bits and sixteen PWM duty bytes. The output
// channel returns one command word per image, in order.
// A word is accepted in every cycle while the pipeline moves. From acceptance,
// a word passes the read of the per-address store, then the sixteen compare
// lanes, then the packing stage and output register, before the command word
// can be taken. The read-modify-write of the store is forwarded, so
// back-to-back words to one address see each other's bytes.
// Reset empties the pipeline and marks every address as never written, so
// the store reads as all zero right away; no clearing pass is needed.
// When the receiver holds ready low, the output word stays, the stages behind
// it fill up and input ready falls once all three stages are occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module pwm_change_delta_packer #(
  parameter int unsigned NUM_ADDRESSES = pcdp_pkg::DEF_NUM_ADDRESSES,
  parameter int unsigned PWM_CHANNELS  = pcdp_pkg::DEF_PWM_CHANNELS
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pcdp_in_if.sink   in_i,
  pcdp_out_if.source out_o
);
  import pcdp_pkg::*;

  localparam int unsigned AW = (NUM_ADDRESSES > 1) ? $clog2(NUM_ADDRESSES) : 1;

  logic [AW-1:0]       slot_tab [ADDR_IN_N];
  logic [AW-1:0]       in_slot;
  logic                in_acc;
  logic                out_free;
  logic                s2_free;
  logic                s1_adv;

  logic                s1_valid_q;
  logic [AW-1:0]       s1_slot_q;
  logic [DIRECT_W-1:0] s1_direct_q;
  logic [PWM_W-1:0]    s1_image_q;
  logic                s1_fwd_q;
  logic [PWM_W-1:0]    s1_fwd_data_q;
  logic                s1_known_q;

  logic [NUM_ADDRESSES-1:0] known_q;
  logic [PWM_W-1:0]    ram_rdata;
  logic [PWM_W-1:0]    prev_bytes;
  logic [PWM_W-1:0]    fresh;
  logic [ALL_CHANNELS-1:0] changed;

  logic                s2_valid_q;
  logic [DIRECT_W-1:0] s2_direct_q;
  logic [ALL_CHANNELS-1:0] s2_mask_q;
  logic [PWM_W-1:0]    s2_fresh_q;

  pack_res_t           merge_res;

  logic                out_valid_q;
  logic [DIRECT_W-1:0] out_direct_q;
  logic [ALL_CHANNELS-1:0] out_mask_q;
  pack_res_t           out_res_q;

  for (genvar a = 0; a < ADDR_IN_N; a++) begin : g_slot
    assign slot_tab[a] = AW'(a % NUM_ADDRESSES);
  end

  assign in_slot  = slot_tab[in_i.module_address];
  assign out_free = !out_valid_q || out_o.ready;
  assign s2_free  = !s2_valid_q || out_free;
  assign s1_adv   = s1_valid_q && s2_free;
  assign in_i.ready = !s1_valid_q || s2_free;
  assign in_acc   = in_i.valid && in_i.ready;

  pcdp_ram #(
    .WIDTH (PWM_W),
    .DEPTH (NUM_ADDRESSES),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_slot_q),
    .wdata_i (fresh),
    .re_i    (in_acc),
    .raddr_i (in_slot),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      known_q    <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        known_q[s1_slot_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_slot_q     <= in_slot;
      s1_direct_q   <= in_i.stop_io ? '0 : in_i.direct_outputs;
      s1_image_q    <= in_i.stop_io ? '0 : {in_i.pwm_bytes_high, in_i.pwm_bytes_low};
      s1_fwd_q      <= s1_adv && (s1_slot_q == in_slot);
      s1_fwd_data_q <= fresh;
      s1_known_q    <= known_q[in_slot];
    end
  end

  assign prev_bytes = s1_fwd_q   ? s1_fwd_data_q :
                      s1_known_q ? ram_rdata     : '0;

  for (genvar c = 0; c < ALL_CHANNELS; c++) begin : g_lane
    pcdp_lane #(
      .ACTIVE (c < PWM_CHANNELS)
    ) u_lane (
      .byte_i    (s1_image_q[c*BYTE_W +: BYTE_W]),
      .prev_i    (prev_bytes[c*BYTE_W +: BYTE_W]),
      .fresh_o   (fresh[c*BYTE_W +: BYTE_W]),
      .changed_o (changed[c])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_free) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_direct_q <= s1_direct_q;
      s2_mask_q   <= changed;
      s2_fresh_q  <= fresh;
    end
    if (s2_valid_q && out_free) begin
      out_direct_q <= s2_direct_q;
      out_mask_q   <= s2_mask_q;
      out_res_q    <= merge_res;
    end
  end

  pcdp_merge u_merge (
    .mask_i  (s2_mask_q),
    .fresh_i (s2_fresh_q),
    .res_o   (merge_res)
  );

  assign out_o.valid         = out_valid_q;
  assign out_o.command_kind  = 1'(out_res_q.kind);
  assign out_o.sent_outputs  = out_direct_q;
  assign out_o.changed_mask  = out_mask_q;
  assign out_o.changed_count = out_res_q.count;
  assign out_o.packed_low    = out_res_q.packed_bytes[HALF_W-1:0];
  assign out_o.packed_high   = out_res_q.packed_bytes[PWM_W-1:HALF_W];
  assign out_o.send_length   = out_res_q.length;

endmodule

`default_nettype wire

FILE: rtl/core/pcdp_checker.sv
// ----------------------------------------------------------------------------
// PWM change packer checker
// Port-level properties of the packer's command words, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pcdp_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          out_valid_i,
  input  wire logic                          out_ready_i,
  input  wire logic                          command_kind_i,
  input  wire logic [pcdp_pkg::DIRECT_W-1:0] sent_outputs_i,
  input  wire logic [15:0]                   changed_mask_i,
  input  wire logic [pcdp_pkg::CNT_W-1:0]    changed_count_i,
  input  wire logic [63:0]                   packed_low_i,
  input  wire logic [63:0]                   packed_high_i,
  input  wire logic [pcdp_pkg::LEN_W-1:0]    send_length_i
);
  import pcdp_pkg::*;

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("command word valid during reset");

  a_data_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (command_kind_i == 1'(CMD_DATA_ONLY))) |->
      (changed_mask_i == '0) && (changed_count_i == '0) &&
      (packed_low_i == '0) && (packed_high_i == '0) &&
      (send_length_i == LEN_DATA_ONLY))
    else $error("data-only word carries PWM fields");

  a_pwm_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (command_kind_i == 1'(CMD_PWM))) |->
      (changed_count_i != '0) &&
      (CNT_W'($countones(changed_mask_i)) == changed_count_i) &&
      (send_length_i == LEN_W'(changed_count_i + LEN_PWM_OVERHEAD)))
    else $error("PWM word mask, count and length disagree");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(sent_outputs_i) && $stable(changed_mask_i) &&
       $stable(packed_low_i) && $stable(packed_high_i)))
    else $error("stalled command word changed");

endmodule

bind pwm_change_delta_packer pcdp_checker u_pcdp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .command_kind_i  (out_o.command_kind),
  .sent_outputs_i  (out_o.sent_outputs),
  .changed_mask_i  (out_o.changed_mask),
  .changed_count_i (out_o.changed_count),
  .packed_low_i    (out_o.packed_low),
  .packed_high_i   (out_o.packed_high),
  .send_length_i   (out_o.send_length)
);

`default_nettype wire

FILE: tb/sv/pcdp_checker.sv
// ----------------------------------------------------------------------------
// PWM change packer checker
// Watches both channels, keeps its own copy of the per-address PWM store,
// predicts the command word for every accepted image and compares each
// accepted command word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module pcdp_scoreboard #(
  parameter int unsigned NUM_ADDRESSES = pcdp_pkg::DEF_NUM_ADDRESSES,
  parameter int unsigned PWM_CHANNELS  = pcdp_pkg::DEF_PWM_CHANNELS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pcdp_in_if          img_i,
  pcdp_out_if         cmd_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import pcdp_pkg::*;

  localparam int unsigned PRINT_CAP = 200;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [DIRECT_W-1:0] sent;
    logic [15:0]        mask;
    logic [CNT_W-1:0]   count;
    logic [HALF_W-1:0]  plo;
    logic [HALF_W-1:0]  phi;
    logic [LEN_W-1:0]   length;
  } pwm_command_t;

  logic [PWM_W-1:0] pwm_store [NUM_ADDRESSES];
  pwm_command_t     command_q [$];
  pwm_command_t     oldest;
  int unsigned      mismatches = 0;
  int unsigned      outstanding = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = outstanding;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < PRINT_CAP) begin
      $display("checker: %s mismatch, got %0h, expected %0h at %0t", what, got, want,
               $realtime);
    end
    mismatches++;
  endtask

  function automatic pwm_command_t pack_image(input logic [5:0] addr, input logic stop,
                                              input logic [DIRECT_W-1:0] direct,
                                              input logic [HALF_W-1:0] lo,
                                              input logic [HALF_W-1:0] hi);
    logic [PWM_W-1:0] fresh;
    logic [PWM_W-1:0] prev;
    logic [PWM_W-1:0] packed_bytes;
    logic [15:0]      mask;
    int unsigned      slot;
    int unsigned      n;
    pwm_command_t     res;
    slot = int'(addr) % NUM_ADDRESSES;
    fresh = stop ? '0 : {hi, lo};
    for (int ch = 0; ch < ALL_CHANNELS; ch++) begin
      if (ch >= PWM_CHANNELS) begin
        fresh[BYTE_W*ch +: BYTE_W] = '0;
      end
    end
    prev = pwm_store[slot];
    packed_bytes = '0;
    mask = '0;
    n = 0;
    for (int ch = 0; ch < PWM_CHANNELS; ch++) begin
      if (fresh[BYTE_W*ch +: BYTE_W] != prev[BYTE_W*ch +: BYTE_W]) begin
        mask[ch] = 1'b1;
        packed_bytes[BYTE_W*n +: BYTE_W] = fresh[BYTE_W*ch +: BYTE_W];
        n++;
      end
    end
    pwm_store[slot] = fresh;
    res.kind   = (n != 0) ? CMD_PWM : CMD_DATA_ONLY;
    res.sent   = stop ? '0 : direct;
    res.mask   = mask;
    res.count  = CNT_W'(n);
    res.plo    = packed_bytes[HALF_W-1:0];
    res.phi    = packed_bytes[PWM_W-1:HALF_W];
    res.length = (n != 0) ? LEN_PWM_OVERHEAD + LEN_W'(n) : LEN_DATA_ONLY;
    return res;
  endfunction

  task automatic check_command(input pwm_command_t want);
    if (cmd_i.command_kind !== want.kind) begin
      report_mismatch("command_kind", 64'(cmd_i.command_kind), 64'(want.kind));
    end
    if (cmd_i.sent_outputs !== want.sent) begin
      report_mismatch("sent_outputs", 64'(cmd_i.sent_outputs), 64'(want.sent));
    end
    if (cmd_i.changed_mask !== want.mask) begin
      report_mismatch("changed_mask", 64'(cmd_i.changed_mask), 64'(want.mask));
    end
    if (cmd_i.changed_count !== want.count) begin
      report_mismatch("changed_count", 64'(cmd_i.changed_count), 64'(want.count));
    end
    if (cmd_i.packed_low !== want.plo) begin
      report_mismatch("packed_low", cmd_i.packed_low, want.plo);
    end
    if (cmd_i.packed_high !== want.phi) begin
      report_mismatch("packed_high", cmd_i.packed_high, want.phi);
    end
    if (cmd_i.send_length !== want.length) begin
      report_mismatch("send_length", 64'(cmd_i.send_length), 64'(want.length));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NUM_ADDRESSES; a++) begin
        pwm_store[a] = '0;
      end
      command_q.delete();
      outstanding = 0;
    end else begin
      if (cmd_i.valid === 1'b1 && cmd_i.ready === 1'b1) begin
        if (command_q.size() == 0) begin
          report_mismatch("unexpected command word", 64'(cmd_i.send_length), 64'd0);
        end else begin
          oldest = command_q.pop_front();
          check_command(oldest);
        end
      end
      if (img_i.valid === 1'b1 && img_i.ready === 1'b1) begin
        command_q.push_back(pack_image(img_i.module_address, img_i.stop_io,
                                       img_i.direct_outputs, img_i.pwm_bytes_low,
                                       img_i.pwm_bytes_high));
      end
      outstanding = command_q.size();
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// PWM change packer testbench
// Drives directed and random output images into the packer under three
// idling regimes, with a drain pause between them, and lets the checker
// judge every command word.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pcdp_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned IMAGES_PER_RUN = 379;
  localparam int unsigned DRAIN_CYCLES   = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned send_idle_pct = 32;
  int unsigned recv_idle_pct = 61;
  int unsigned cycles = 0;
  int unsigned fail_count;
  int unsigned pending;

  logic [PWM_W-1:0] last_image [ADDR_IN_N];

  pcdp_in_if  img_bus ();
  pcdp_out_if cmd_bus ();

  pwm_change_delta_packer dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (img_bus),
    .out_o  (cmd_bus)
  );

  pcdp_scoreboard u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .img_i        (img_bus),
    .cmd_i        (cmd_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk) begin
    cmd_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_image(input logic [5:0] addr, input logic stop,
                            input logic [15:0] direct, input logic [63:0] lo,
                            input logic [63:0] hi);
    while ($urandom_range(99) < send_idle_pct) begin
      img_bus.valid          <= 1'b0;
      img_bus.module_address <= 6'($urandom);
      img_bus.stop_io        <= 1'($urandom);
      img_bus.direct_outputs <= 16'($urandom);
      img_bus.pwm_bytes_low  <= {$urandom, $urandom};
      img_bus.pwm_bytes_high <= {$urandom, $urandom};
      @(negedge clk);
    end
    img_bus.valid          <= 1'b1;
    img_bus.module_address <= addr;
    img_bus.stop_io        <= stop;
    img_bus.direct_outputs <= direct;
    img_bus.pwm_bytes_low  <= lo;
    img_bus.pwm_bytes_high <= hi;
    last_image[addr] = stop ? '0 : {hi, lo};
    do @(posedge clk); while (img_bus.ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic random_image();
    logic [5:0]       addr;
    logic             stop;
    logic [15:0]      direct;
    logic [PWM_W-1:0] image;
    int unsigned      pick;
    int unsigned      ch;
    pick = $urandom_range(99);
    addr = $urandom_range(1) ? 6'($urandom_range(3)) : 6'($urandom_range(63));
    direct = 16'($urandom);
    stop = 1'b0;
    image = last_image[addr];
    if (pick < 8) begin
      stop = 1'b1;
      image = {$urandom, $urandom, $urandom, $urandom};
    end else if (pick < 30) begin
      image = {$urandom, $urandom, $urandom, $urandom};
    end else if (pick >= 45) begin
      repeat ($urandom_range(1, 16)) begin
        ch = $urandom_range(15);
        image[BYTE_W*ch +: BYTE_W] = 8'($urandom);
      end
    end
    send_image(addr, stop, direct, image[HALF_W-1:0], image[PWM_W-1:HALF_W]);
  endtask

  task automatic wait_drained();
    img_bus.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    img_bus.valid          = 1'b0;
    img_bus.module_address = '0;
    img_bus.stop_io        = 1'b0;
    img_bus.direct_outputs = '0;
    img_bus.pwm_bytes_low  = '0;
    img_bus.pwm_bytes_high = '0;
    for (int a = 0; a < ADDR_IN_N; a++) begin
      last_image[a] = '0;
    end
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_image(6'd0, 1'b0, 16'h0000, '0, '0);
    send_image(6'd0, 1'b0, 16'hffff, '1, '1);
    send_image(6'd0, 1'b0, 16'hffff, '1, '1);
    send_image(6'd0, 1'b1, 16'hffff, '1, '1);
    send_image(6'd63, 1'b0, 16'ha5a5, 64'h0000_0000_0000_0001, '0);
    send_image(6'd63, 1'b0, 16'h5a5a, 64'h0000_0000_0000_0001, 64'hff00_0000_0000_0000);
    send_image(6'd63, 1'b0, 16'haaaa, 64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555);
    send_image(6'd63, 1'b0, 16'h5555, 64'haaaa_aaaa_aaaa_aaaa, 64'haaaa_aaaa_aaaa_aaaa);
    send_image(6'd1, 1'b0, 16'h8001, 64'h0000_0000_0000_0080, 64'h8000_0000_0000_0000);
    send_image(6'd1, 1'b1, 16'h0000, '0, '0);
    send_image(6'd1, 1'b1, 16'hffff, '1, '1);
    send_image(6'd32, 1'b0, 16'h0001, '1, '0);
    send_image(6'd32, 1'b0, 16'h8000, '1, '1);
    send_image(6'd2, 1'b0, 16'h1234, 64'h0101_0101_0101_0101, 64'h0101_0101_0101_0101);
    send_image(6'd2, 1'b0, 16'h4321, 64'h0101_0101_0001_0101, 64'h0101_0100_0101_0101);
    send_image(6'd62, 1'b0, 16'h0f0f, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    wait_drained();

    for (int run = 0; run < 3; run++) begin
      case (run)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct = 61;
        end
        1: begin
          send_idle_pct = 61;
          recv_idle_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (IMAGES_PER_RUN) random_image();
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: pwm_change_delta_packer.f
rtl/core/pcdp_pkg.sv
rtl/core/pcdp_in_if.sv
rtl/core/pcdp_out_if.sv
rtl/core/pcdp_ram.sv
rtl/core/pcdp_lane.sv
rtl/core/pcdp_merge.sv
rtl/core/pwm_change_delta_packer.sv
rtl/core/pcdp_checker.sv
tb/sv/pcdp_checker.sv
tb/sv/testbench.sv
